// ===== hw/rtl/lru_pr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// Used by lru_pr_front, lru_pr_back, lru_page_replacement_top and the testbench; no other dependencies.

package lru_pr_pkg;

    // Fixed widths of the register and the stream fields.
    localparam int CFG_W       = 4;
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 3;
    localparam int TOTAL_W     = 32;
    localparam int OUT_DATA_W  = 72;

    // Frame count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Saturation value of every running counter.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // One result as it leaves the back end.
    typedef struct packed {
        logic [TOTAL_W-1:0]     total_hits;
        logic [TOTAL_W-1:0]     total_faults;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   hit;
    } result_t;

    // Saturating increment of a running counter.
    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] r;
        r = (v == TOTAL_MAX) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== hw/rtl/lru_pr_front.sv =====
// Front end of the LRU page replacement block: accepts page references,
// trims them to the page width and holds them in a two-entry queue.
// Depends on lru_pr_pkg.

module lru_pr_front #(
    parameter int PAGE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lru_pr_pkg::PAGE_IN_W-1:0] in_page,
    output logic                            q_valid,
    output logic [PAGE_BITS-1:0]            q_page,
    input  logic                            q_pop
);

    import lru_pr_pkg::*;

    localparam int EXT_W = PAGE_IN_W + 32;

    logic [EXT_W-1:0]     page_ext;
    logic [PAGE_BITS-1:0] page_trim;
    logic [PAGE_BITS-1:0] entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic                 push;
    logic                 pop;

    // Only the low PAGE_BITS bits of a reference take part.
    assign page_ext  = {32'b0, in_page};
    assign page_trim = page_ext[PAGE_BITS-1:0];

    // Queue handshakes.
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_page   = entry_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= page_trim;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/lru_pr_back.sv =====
// Back end of the LRU page replacement block: scans the frame table one
// frame per cycle, picks the hit, empty or oldest frame, updates the table
// and holds the result register. Depends on lru_pr_pkg.

module lru_pr_back #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] last_frame,
    input  logic                  q_valid,
    input  logic [PAGE_BITS-1:0]  q_page,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lru_pr_pkg::result_t   out_result
);

    import lru_pr_pkg::*;

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [FIDX_W-1:0]   scan_addr_reg;
    logic                issuing_reg;
    logic                pend_valid_reg;
    logic                pend_last_reg;
    logic [FIDX_W-1:0]   pend_idx_reg;
    logic                hit_found_reg;
    logic [FIDX_W-1:0]   hit_idx_reg;
    logic                empty_found_reg;
    logic [FIDX_W-1:0]   empty_idx_reg;
    logic [TOTAL_W-1:0]  best_stamp_reg;
    logic [FIDX_W-1:0]   best_idx_reg;
    logic [FRAMES-1:0]   valid_reg;
    logic [TOTAL_W-1:0]  use_count_reg;
    logic [TOTAL_W-1:0]  fault_count_reg;
    logic [TOTAL_W-1:0]  hit_count_reg;
    logic                res_hit_reg;
    logic [FIDX_W-1:0]   res_idx_reg;
    logic                out_valid_reg;
    result_t             out_result_reg;

    logic [PAGE_BITS-1:0] page_mem  [FRAMES];
    logic [TOTAL_W-1:0]   stamp_mem [FRAMES];
    logic [PAGE_BITS-1:0] page_rd_reg;
    logic [TOTAL_W-1:0]   stamp_rd_reg;

    logic                 pend_frame_valid;
    logic                 chosen_hit;
    logic [FIDX_W-1:0]    chosen_idx;
    logic [TOTAL_W-1:0]   use_count_next;
    logic [FIDX_W+2:0]    idx_ext;
    logic                 table_we;

    // Frame choice at the end of a scan.
    always_comb
    begin
        chosen_hit = hit_found_reg;
        priority if (hit_found_reg)
        begin
            chosen_idx = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            chosen_idx = empty_idx_reg;
        end
        else
        begin
            chosen_idx = best_idx_reg;
        end
    end

    assign pend_frame_valid = valid_reg[pend_idx_reg];
    assign use_count_next   = sat_inc(use_count_reg);
    assign table_we         = (state_reg == ST_DECIDE);
    assign idx_ext          = {3'b000, res_idx_reg};
    assign q_pop            = (state_reg == ST_IDLE) && q_valid;
    assign out_valid        = out_valid_reg;
    assign out_result       = out_result_reg;

    // Frame table: one read address per cycle, one write at the decision.
    always_ff @(posedge clk)
    begin
        page_rd_reg  <= page_mem[scan_addr_reg];
        stamp_rd_reg <= stamp_mem[scan_addr_reg];
        if (table_we)
        begin
            stamp_mem[chosen_idx] <= use_count_next;
            if (!chosen_hit)
            begin
                page_mem[chosen_idx] <= page_reg;
            end
        end
    end

    // Sequencer, scan trackers, counters and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            page_reg        <= '0;
            scan_addr_reg   <= '0;
            issuing_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_last_reg   <= 1'b0;
            pend_idx_reg    <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            best_stamp_reg  <= '0;
            best_idx_reg    <= '0;
            valid_reg       <= '0;
            use_count_reg   <= '0;
            fault_count_reg <= '0;
            hit_count_reg   <= '0;
            res_hit_reg     <= 1'b0;
            res_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_result_reg  <= '0;
        end
        else
        begin
            // The receiver takes the waiting result; in ST_DONE the load
            // below decides the valid flag instead.
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        page_reg        <= q_page;
                        scan_addr_reg   <= '0;
                        issuing_reg     <= 1'b1;
                        pend_valid_reg  <= 1'b0;
                        pend_last_reg   <= 1'b0;
                        hit_found_reg   <= 1'b0;
                        empty_found_reg <= 1'b0;
                        state_reg       <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    // Issue the next frame read.
                    pend_valid_reg <= issuing_reg;
                    pend_idx_reg   <= scan_addr_reg;
                    pend_last_reg  <= issuing_reg && (scan_addr_reg == last_frame);
                    if (issuing_reg)
                    begin
                        if (scan_addr_reg == last_frame)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            scan_addr_reg <= scan_addr_reg + 1'b1;
                        end
                    end

                    // Examine the frame read in the previous cycle.
                    if (pend_valid_reg)
                    begin
                        if (!hit_found_reg && pend_frame_valid && (page_rd_reg == page_reg))
                        begin
                            hit_found_reg <= 1'b1;
                            hit_idx_reg   <= pend_idx_reg;
                        end
                        if (!empty_found_reg && !pend_frame_valid)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_idx_reg   <= pend_idx_reg;
                        end
                        if ((pend_idx_reg == '0) || (stamp_rd_reg < best_stamp_reg))
                        begin
                            best_stamp_reg <= stamp_rd_reg;
                            best_idx_reg   <= pend_idx_reg;
                        end
                        if (pend_last_reg)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE:
                begin
                    use_count_reg          <= use_count_next;
                    valid_reg[chosen_idx]  <= 1'b1;
                    res_hit_reg            <= chosen_hit;
                    res_idx_reg            <= chosen_idx;
                    if (chosen_hit)
                    begin
                        hit_count_reg <= sat_inc(hit_count_reg);
                    end
                    else
                    begin
                        fault_count_reg <= sat_inc(fault_count_reg);
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_result_reg.hit          <= res_hit_reg;
                        out_result_reg.frame_index  <= idx_ext[FRAME_OUT_W-1:0];
                        out_result_reg.total_faults <= fault_count_reg;
                        out_result_reg.total_hits   <= hit_count_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: frame count register,
// front end with its request queue, and the table scanning back end.
// Depends on lru_pr_pkg, lru_pr_front and lru_pr_back.
//
// Usage:
//   s_axis carries one page reference per request (tdata = page_number).
//   m_axis returns one result per reference: hit flag, frame used and the
//   saturating fault and hit totals.
//   cfg_wr_en / cfg_wr_data write the number of frames in use (1..8; zero
//   acts as one, values above FRAMES act as FRAMES). Write it only while no
//   reference is in flight.
// Timing:
//   The back end reads one frame of the table per cycle through a single
//   read port. A reference passes through the input queue, the pipelined
//   scan over the N frames in use, a decide step and the load of the output
//   register. The back end works on one reference at a time; the queue
//   takes further references meanwhile.
// Reset and stalls:
//   Reset empties every frame, clears all counters and sets the frame count
//   to 8. A two-entry queue takes requests while the back end works; when
//   the receiver stalls the result waits in the output register, the back
//   end holds its next result, and the queue fills before s_axis_tready
//   drops.

module lru_page_replacement_top #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: frames_in_use.
    input  logic                             cfg_wr_en,
    input  logic [lru_pr_pkg::CFG_W-1:0]     cfg_wr_data,
    // Page references.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lru_pr_pkg::PAGE_IN_W-1:0] s_axis_tdata,   // [15:0] page_number
    // Results.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] hit, [3:1] frame_index, [35:4] total_faults, [67:36] total_hits,
    // [71:68] zero
    output logic [lru_pr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import lru_pr_pkg::*;

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [7:0] FRAMES8 = 8'(FRAMES);

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic [7:0]           cfg_ext;
    logic [7:0]           count8;
    logic [7:0]           last8;
    logic [FIDX_W-1:0]    last_frame;
    logic                 q_valid;
    logic [PAGE_BITS-1:0] q_page;
    logic                 q_pop;
    result_t              result;

    // Frame count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            frames_in_use_reg <= cfg_wr_data;
        end
    end

    // Clamp the frame count and form the last frame index of a scan.
    always_comb
    begin
        cfg_ext = {4'b0000, frames_in_use_reg};
        priority if (cfg_ext == 8'd0)
        begin
            count8 = 8'd1;
        end
        else if (cfg_ext > FRAMES8)
        begin
            count8 = FRAMES8;
        end
        else
        begin
            count8 = cfg_ext;
        end
        last8 = count8 - 8'd1;
    end

    assign last_frame = last8[FIDX_W-1:0];

    lru_pr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_page  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_page   (q_page),
        .q_pop    (q_pop)
    );

    lru_pr_back #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_frame (last_frame),
        .q_valid    (q_valid),
        .q_page     (q_page),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result fields, highest field first, hit flag in bit 0.
    assign m_axis_tdata = {4'b0000, result.total_hits, result.total_faults,
                           result.frame_index, result.hit};

endmodule

// ===== tb/sv/tb_lru_page_replacement_top.sv =====
// Self-checking testbench for lru_page_replacement_top: directed and random
// page references are checked against an in-bench LRU frame table predictor.
// Depends on lru_pr_pkg and lru_page_replacement_top.
`timescale 1ns / 1ps

module tb_lru_page_replacement_top;

    import lru_pr_pkg::*;

    localparam int FRAMES        = 8;
    localparam int PAGE_BITS     = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BLOCK_ITEMS   = 70;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data = CFG_RESET;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PAGE_IN_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted frame table, counters and frame count register.
    logic [PAGE_IN_W-1:0]  page_of_frame [FRAMES];
    logic                  frame_busy [FRAMES];
    logic [TOTAL_W-1:0]    stamp_of_frame [FRAMES];
    logic [TOTAL_W-1:0]    use_clock;
    logic [TOTAL_W-1:0]    fault_total;
    logic [TOTAL_W-1:0]    hit_total;
    logic [CFG_W-1:0]      frame_count_reg;

    result_t               pending_results [$];
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    int                    sender_idle_pct = 0;
    int                    receiver_stall_pct = 0;

    lru_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Global watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver backpressure, one decision per cycle.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic [TOTAL_W-1:0] bump_saturating(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

    // Looks the page up in the predicted table, updates it and returns
    // the result the block should produce for this request.
    function automatic result_t predict_reference(input logic [PAGE_IN_W-1:0] page);
        int unsigned        active;
        int unsigned        chosen;
        bit                 found;
        bit                 placed;
        logic [TOTAL_W-1:0] oldest;
        result_t            r;
        active = (frame_count_reg == 0) ? 1 :
                 (frame_count_reg > FRAMES) ? FRAMES : frame_count_reg;
        found  = 1'b0;
        placed = 1'b0;
        chosen = 0;
        for (int unsigned f = 0; f < active; f++)
        begin
            if (!found && frame_busy[f] && page_of_frame[f] == page)
            begin
                chosen = f;
                found  = 1'b1;
            end
        end
        if (found)
        begin
            hit_total = bump_saturating(hit_total);
        end
        else
        begin
            // Lowest empty frame first, otherwise the oldest stamp wins.
            for (int unsigned f = 0; f < active; f++)
            begin
                if (!placed && !frame_busy[f])
                begin
                    chosen = f;
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                oldest = stamp_of_frame[0];
                chosen = 0;
                for (int unsigned f = 1; f < active; f++)
                begin
                    if (stamp_of_frame[f] < oldest)
                    begin
                        oldest = stamp_of_frame[f];
                        chosen = f;
                    end
                end
            end
            frame_busy[chosen]    = 1'b1;
            page_of_frame[chosen] = page;
            fault_total = bump_saturating(fault_total);
        end
        use_clock = bump_saturating(use_clock);
        stamp_of_frame[chosen] = use_clock;
        r.hit          = found;
        r.frame_index  = chosen[FRAME_OUT_W-1:0];
        r.total_faults = fault_total;
        r.total_hits   = hit_total;
        return r;
    endfunction

    task report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                         input logic [TOTAL_W-1:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result checker. Sampling on the falling edge sees values that hold
    // through the rising edge on which the handshake completes.
    always @(negedge clk)
    begin : result_check
        result_t observed;
        result_t wanted;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            observed = m_axis_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unrequested result", observed.total_faults, '0);
            end
            else
            begin
                wanted = pending_results.pop_front();
                if (observed.hit != wanted.hit)
                    report_mismatch("hit", TOTAL_W'(observed.hit), TOTAL_W'(wanted.hit));
                if (observed.frame_index != wanted.frame_index)
                    report_mismatch("frame_index", TOTAL_W'(observed.frame_index),
                                    TOTAL_W'(wanted.frame_index));
                if (observed.total_faults != wanted.total_faults)
                    report_mismatch("total_faults", observed.total_faults, wanted.total_faults);
                if (observed.total_hits != wanted.total_hits)
                    report_mismatch("total_hits", observed.total_hits, wanted.total_hits);
                if (m_axis_tdata[OUT_DATA_W-1:$bits(result_t)] != '0)
                    report_mismatch("pad bits",
                                    TOTAL_W'(m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]), '0);
            end
        end
    end

    // Sends one page reference and records its prediction on acceptance.
    // Valid stays high afterwards so back-to-back requests need no gap.
    task send_page(input logic [PAGE_IN_W-1:0] page);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        pending_results.push_back(predict_reference(page));
    endtask

    // Lowers valid and waits for every pending result.
    task drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Frame count write, only with the block idle.
    task write_frame_count(input logic [CFG_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        frame_count_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Field extremes, fill of empty frames, hits and LRU eviction.
    task test_directed_extremes();
        logic [PAGE_IN_W-1:0] seq [12];
        seq = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001,
                16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'hFFFF, 16'h5555};
        set_idling(0, 0);
        foreach (seq[i])
            send_page(seq[i]);
        drain_results();
    endtask

    // Shrinking and growing the frame count, plus zero and oversized counts.
    task test_frame_count_changes();
        write_frame_count(4'd2);
        send_page(16'hAAAA);
        send_page(16'h0003);
        send_page(16'h0002);
        write_frame_count(4'd0);
        send_page(16'h1234);
        send_page(16'h1234);
        send_page(16'h4321);
        write_frame_count(4'd15);
        send_page(16'h0004);
        send_page(16'h0005);
        send_page(16'h8000);
        send_page(16'h7FFF);
        send_page(16'h0001);
        write_frame_count(4'd8);
        send_page(16'h1234);
        drain_results();
    endtask

    // Random traffic: mostly references into a small working set so that
    // hits and evictions dominate, the rest arbitrary pages.
    task test_random_traffic();
        int                   sender_pcts [4];
        int                   receiver_pcts [4];
        logic [CFG_W-1:0]     counts [12];
        logic [PAGE_IN_W-1:0] base;
        logic [PAGE_IN_W-1:0] page;
        int                   span;
        sender_pcts   = '{0, 88, 0, 22};
        receiver_pcts = '{0, 0, 88, 22};
        counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7, 4'd6, 4'd4, 4'd9, 4'd12};
        for (int phase = 0; phase < 4; phase++)
        begin
            set_idling(sender_pcts[phase], receiver_pcts[phase]);
            for (int blk = 0; blk < 5; blk++)
            begin
                write_frame_count(counts[$urandom_range(11)]);
                base = PAGE_IN_W'($urandom);
                span = $urandom_range(1, 11);
                for (int i = 0; i < BLOCK_ITEMS; i++)
                begin
                    if ($urandom_range(99) < 80)
                        page = PAGE_IN_W'(base + $urandom_range(span - 1));
                    else
                        page = PAGE_IN_W'($urandom);
                    send_page(page);
                    // Occasionally hold off until the block has caught up.
                    if ((phase == 0 && blk == 0 && i == BLOCK_ITEMS / 2) ||
                        $urandom_range(199) == 0)
                        drain_results();
                end
            end
        end
        drain_results();
    endtask

    initial
    begin
        // Predictor starts from the reset state.
        foreach (frame_busy[i])
        begin
            frame_busy[i]     = 1'b0;
            page_of_frame[i]  = '0;
            stamp_of_frame[i] = '0;
        end
        use_clock       = '0;
        fault_total     = '0;
        hit_total       = '0;
        frame_count_reg = CFG_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_frame_count_changes();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lru_page_replacement_top.f =====
hw/rtl/lru_pr_pkg.sv
hw/rtl/lru_pr_front.sv
hw/rtl/lru_pr_back.sv
hw/rtl/lru_page_replacement_top.sv
tb/sv/tb_lru_page_replacement_top.sv
